// File: hdl/aec_pkg.sv
// shared constants for the arithmetic encoder core
package aec_pkg;

    // default code range, frequency and pending counter widths
    localparam int CODE_BITS_DEF   = 16;
    localparam int FREQ_BITS_DEF   = 14;
    localparam int FOLLOW_BITS_DEF = 32;

    // most runs emitted for one encode transaction
    localparam int MAX_RESULTS  = 16;
    localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

    // width of the opposite bit count carried on the result channel
    localparam int OPP_W       = 32;
    localparam int OUT_TDATA_W = ((1 + OPP_W + 7) / 8) * 8;

    // request kinds carried on s_tuser
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

endpackage

// File: hdl/aec_muldiv.sv
// serial multiply-divide lane: floor(span*mult/divisor), one span bit per step cycle
module aec_muldiv #(
    parameter int CODE_BITS = 16,
    parameter int FREQ_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 step,
    input  logic                 span_bit,
    input  logic [FREQ_BITS-1:0] mult,
    input  logic [FREQ_BITS-1:0] divisor,
    output logic [CODE_BITS:0]   quot
);

    localparam int T_W = FREQ_BITS + 2;

    logic [FREQ_BITS-1:0] rem_reg;
    logic [FREQ_BITS-1:0] rem_next;
    logic [CODE_BITS:0]   quot_reg;
    logic [CODE_BITS:0]   quot_next;

    logic [T_W-1:0] t_sum;
    logic [T_W-1:0] div1;
    logic [T_W-1:0] div2;
    logic [T_W-1:0] t_rem;
    logic [1:0]     digit;

    // remainder stays below the divisor, so each step subtracts it at most twice
    always_comb
    begin
        t_sum = {1'b0, rem_reg, 1'b0} + (span_bit ? T_W'(mult) : '0);
        div1  = T_W'(divisor);
        div2  = {1'b0, divisor, 1'b0};
        if (t_sum >= div2)
        begin
            digit = 2'd2;
            t_rem = t_sum - div2;
        end
        else if (t_sum >= div1)
        begin
            digit = 2'd1;
            t_rem = t_sum - div1;
        end
        else
        begin
            digit = 2'd0;
            t_rem = t_sum;
        end

        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            rem_next  = '0;
            quot_next = '0;
        end
        else if (step)
        begin
            rem_next  = t_rem[FREQ_BITS-1:0];
            quot_next = {quot_reg[CODE_BITS-1:0], 1'b0} + (CODE_BITS + 1)'(digit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// File: hdl/arithmetic_encoder_core.sv
// arithmetic encoder core: range update, renormalization and run output
// encode: serial multiply-divide (ST_DIV), range update (ST_UPD), renormalization
// steps in ST_RENORM (up to CODE_BITS, at most MAX_RESULTS runs) and the end of the scan,
// then ST_FLUSH hands over the last run if one is held; output stalls can hold it up
// a finish transaction passes through ST_FLUSH; a rejected encode transaction is dropped
// the serial span shift register (one span bit per cycle) sets the encode time
// reset restarts the range to [0, 2^CODE_BITS-1], clears the pending count, empties output
module arithmetic_encoder_core
    import aec_pkg::*;
#(
    parameter int CODE_BITS   = CODE_BITS_DEF,
    parameter int FREQ_BITS   = FREQ_BITS_DEF,
    parameter int FOLLOW_BITS = FOLLOW_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,

    // request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // cum_upper, cum_lower, freq_total, zero pad
    input  logic [((3 * FREQ_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic [0:0]                            s_tuser,

    // run channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // lead_bit, opposite_count, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // last_of_run
    output logic                   m_tlast
);

    localparam int CNT_W = $clog2(CODE_BITS + 1);
    localparam logic [CODE_BITS-1:0] HALF = {1'b1, {(CODE_BITS - 1){1'b0}}};
    localparam logic [CODE_BITS-1:0] QTR1 = {2'b01, {(CODE_BITS - 2){1'b0}}};
    localparam logic [CODE_BITS-1:0] QTR3 = {2'b11, {(CODE_BITS - 2){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_RENORM,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    // coding state
    logic [CODE_BITS-1:0]   low_reg, low_next;
    logic [CODE_BITS-1:0]   high_reg, high_next;
    logic [FOLLOW_BITS-1:0] pending_reg, pending_next;

    // captured request and serial span
    logic [FREQ_BITS-1:0] cu_reg, cu_next;
    logic [FREQ_BITS-1:0] cl_reg, cl_next;
    logic [FREQ_BITS-1:0] tot_reg, tot_next;
    logic [CODE_BITS:0]   span_reg, span_next;

    // step counter shared by the divide and renormalization phases
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [RESULT_CNT_W-1:0] n_reg, n_next;

    // run held back until we know whether it closes the transaction
    logic             held_valid_reg, held_valid_next;
    logic             held_lead_reg, held_lead_next;
    logic [OPP_W-1:0] held_count_reg, held_count_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic             m_lead_reg, m_lead_next;
    logic [OPP_W-1:0] m_count_reg, m_count_next;
    logic             m_last_reg, m_last_next;

    logic                   lane_start;
    logic                   lane_step;
    logic [CODE_BITS:0]     q_hi;
    logic [CODE_BITS:0]     q_lo;

    logic                   req_kind;
    logic [FREQ_BITS-1:0]   in_cu;
    logic [FREQ_BITS-1:0]   in_cl;
    logic [FREQ_BITS-1:0]   in_tot;
    logic                   bad_freq;
    logic                   out_free;
    logic [FOLLOW_BITS-1:0] pending_inc;
    logic [FOLLOW_BITS+OPP_W-1:0] pend_ext;
    logic [FOLLOW_BITS+OPP_W-1:0] pend_inc_ext;
    logic                   emit_zero;
    logic                   emit_one;
    logic                   mid_step;
    logic                   stop_renorm;
    logic [CODE_BITS-1:0]   low_adj;
    logic [CODE_BITS-1:0]   high_adj;

    // request fields, lowest first
    assign req_kind = s_tuser[0];
    assign in_cu    = s_tdata[FREQ_BITS-1:0];
    assign in_cl    = s_tdata[2*FREQ_BITS-1:FREQ_BITS];
    assign in_tot   = s_tdata[3*FREQ_BITS-1:2*FREQ_BITS];

    // malformed slot: encode transaction is dropped without effect
    assign bad_freq = (in_tot == '0) || (in_cu > in_tot) || (in_cl >= in_cu);

    // high bound and low bound lanes run side by side over the same span bits
    aec_muldiv #(
        .CODE_BITS (CODE_BITS),
        .FREQ_BITS (FREQ_BITS)
    ) u_lane_hi (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lane_start),
        .step     (lane_step),
        .span_bit (span_reg[CODE_BITS]),
        .mult     (cu_reg),
        .divisor  (tot_reg),
        .quot     (q_hi)
    );

    aec_muldiv #(
        .CODE_BITS (CODE_BITS),
        .FREQ_BITS (FREQ_BITS)
    ) u_lane_lo (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lane_start),
        .step     (lane_step),
        .span_bit (span_reg[CODE_BITS]),
        .mult     (cl_reg),
        .divisor  (tot_reg),
        .quot     (q_lo)
    );

    // saturating pending count and its low word for the result channel
    assign pending_inc  = (&pending_reg) ? pending_reg : pending_reg + 1'b1;
    assign pend_ext     = {{OPP_W{1'b0}}, pending_reg};
    assign pend_inc_ext = {{OPP_W{1'b0}}, pending_inc};

    // renormalization decision for the current range
    assign emit_zero   = (high_reg < HALF);
    assign emit_one    = !emit_zero && (low_reg >= HALF);
    assign mid_step    = !emit_zero && !emit_one && (low_reg >= QTR1) && (high_reg < QTR3);
    assign stop_renorm = (cnt_reg == CNT_W'(CODE_BITS))
                      || (n_reg == RESULT_CNT_W'(MAX_RESULTS))
                      || !(emit_zero || emit_one || mid_step);
    assign low_adj     = mid_step ? low_reg - QTR1 : low_reg;
    assign high_adj    = mid_step ? high_reg - QTR1 : high_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        pending_next    = pending_reg;
        cu_next         = cu_reg;
        cl_next         = cl_reg;
        tot_next        = tot_reg;
        span_next       = span_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        held_valid_next = held_valid_reg;
        held_lead_next  = held_lead_reg;
        held_count_next = held_count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_lead_next     = m_lead_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        lane_start      = 1'b0;
        lane_step       = 1'b0;

        // current result leaves the output register
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (req_kind == REQ_FINISH)
                    begin
                        // one more pending bit, lead picks the quarter holding low
                        held_valid_next = 1'b1;
                        held_lead_next  = (low_reg >= QTR1);
                        held_count_next = pend_inc_ext[OPP_W-1:0];
                        pending_next    = '0;
                        state_next      = ST_FLUSH;
                    end
                    else if (!bad_freq)
                    begin
                        cu_next    = in_cu;
                        cl_next    = in_cl;
                        tot_next   = in_tot;
                        span_next  = {1'b0, high_reg} - {1'b0, low_reg} + 1'b1;
                        cnt_next   = '0;
                        lane_start = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // feed span msb first to both lanes
                lane_step = 1'b1;
                span_next = {span_reg[CODE_BITS-1:0], 1'b0};
                if (cnt_reg == CNT_W'(CODE_BITS))
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_UPD:
            begin
                high_next       = low_reg + q_hi[CODE_BITS-1:0] - 1'b1;
                low_next        = low_reg + q_lo[CODE_BITS-1:0];
                cnt_next        = '0;
                n_next          = '0;
                held_valid_next = 1'b0;
                state_next      = ST_RENORM;
            end

            ST_RENORM:
            begin
                if (stop_renorm)
                begin
                    state_next = held_valid_reg ? ST_FLUSH : ST_IDLE;
                end
                else if (emit_zero || emit_one)
                begin
                    // a new run pushes the previous one out as not last
                    if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            m_tvalid_next = 1'b1;
                            m_lead_next   = held_lead_reg;
                            m_count_next  = held_count_reg;
                            m_last_next   = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_lead_next  = emit_one;
                        held_count_next = pend_ext[OPP_W-1:0];
                        pending_next    = '0;
                        n_next          = n_reg + 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                        low_next        = {low_reg[CODE_BITS-2:0], 1'b0};
                        high_next       = {high_reg[CODE_BITS-2:0], 1'b1};
                    end
                end
                else
                begin
                    // middle half: defer one opposite bit
                    pending_next = pending_inc;
                    cnt_next     = cnt_reg + 1'b1;
                    low_next     = {low_adj[CODE_BITS-2:0], 1'b0};
                    high_next    = {high_adj[CODE_BITS-2:0], 1'b1};
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    m_tvalid_next   = 1'b1;
                    m_lead_next     = held_lead_reg;
                    m_count_next    = held_count_reg;
                    m_last_next     = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_reg        <= '0;
            high_reg       <= '1;
            pending_reg    <= '0;
            cu_reg         <= '0;
            cl_reg         <= '0;
            tot_reg        <= '0;
            span_reg       <= '0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            held_valid_reg <= 1'b0;
            held_lead_reg  <= 1'b0;
            held_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            m_lead_reg     <= 1'b0;
            m_count_reg    <= '0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pending_reg    <= pending_next;
            cu_reg         <= cu_next;
            cl_reg         <= cl_next;
            tot_reg        <= tot_next;
            span_reg       <= span_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            held_valid_reg <= held_valid_next;
            held_lead_reg  <= held_lead_next;
            held_count_reg <= held_count_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_lead_reg     <= m_lead_next;
            m_count_reg    <= m_count_next;
            m_last_reg     <= m_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 1 - OPP_W){1'b0}}, m_count_reg, m_lead_reg};
    assign m_tlast  = m_last_reg;

    // no run may be left behind once the core is back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !held_valid_reg)
        else $error("held run left over in idle");

    // run count per encode transaction stays within the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RENORM) |-> (n_reg <= RESULT_CNT_W'(MAX_RESULTS)))
        else $error("too many runs for one transaction");

    // a finish transaction moves its pending bits into the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] == REQ_FINISH)
        |=> (pending_reg == '0) && (state_reg == ST_FLUSH))
        else $error("finish did not clear pending count");

    // flushing always closes the transaction with a last run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && out_free) |=> (m_tvalid_reg && m_last_reg))
        else $error("flush did not deliver a last run");

    // serial divide never runs past the span width
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(CODE_BITS)))
        else $error("divide step count out of range");

endmodule
